FILE: src/ptc_pkg.sv
package ptc_pkg;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned PRESCALE_W = 11;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned SEL_W      = 3;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_COUNTER = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WR_FLAGS   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CLK_SEL       = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM_MODE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMPARE_A     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMPARE_B     = 8'd3;

	localparam logic [SEL_W-1:0] SEL_STOPPED  = 3'd0;
	localparam logic [SEL_W-1:0] SEL_DIV8     = 3'd2;
	localparam logic [SEL_W-1:0] SEL_DIV64    = 3'd3;
	localparam logic [SEL_W-1:0] SEL_DIV256   = 3'd4;
	localparam logic [SEL_W-1:0] SEL_DIV1024  = 3'd5;

	localparam logic [MODE_W-1:0] MODE_CTC_A   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PWM_A   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_FAST_A  = 3'd7;

	localparam logic [DATA_W-1:0] COUNTER_TOP = 8'hFF;

	localparam int unsigned FLAG_OVERFLOW_BIT = 0;
	localparam int unsigned FLAG_MATCH_A_BIT  = 1;
	localparam int unsigned FLAG_MATCH_B_BIT  = 2;

	typedef struct packed {
		logic [SEL_W-1:0]  clk_sel;
		logic [MODE_W-1:0] waveform_mode;
		logic [DATA_W-1:0] compare_a;
		logic [DATA_W-1:0] compare_b;
	} cfg_t;

	typedef struct packed {
		logic [PRESCALE_W-1:0] prescale_count;
		logic [DATA_W-1:0]     counter;
		logic [DATA_W-1:0]     flags;
	} timer_state_t;

	function automatic logic [PRESCALE_W-1:0] divisor_of(input logic [SEL_W-1:0] sel);
		logic [PRESCALE_W-1:0] d;
		case (sel)
			SEL_DIV8:    d = 11'd8;
			SEL_DIV64:   d = 11'd64;
			SEL_DIV256:  d = 11'd256;
			SEL_DIV1024: d = 11'd1024;
			default:     d = 11'd1;
		endcase
		return d;
	endfunction

endpackage

FILE: src/prescaled_timer_counter_8bit.sv
// Eight-bit timer/counter with a clock prescaler, an overflow flag and two
// compare units. Each input item is a tick or a software write of the counter
// or the flag byte, and each one yields exactly one result item holding the
// counter, the flag byte and whether the counter stepped. An item is taken
// into an input register, updated against the timer state by combinational
// logic and placed in an output register. One item is accepted every clock
// cycle while the sink takes the results, and each result is presented from
// the output register once its item has moved on from the input register.
// A result held by the sink keeps the input register full, and the block
// then takes no new item until it moves.
// Configuration writes are always ready and take effect at once.
module prescaled_timer_counter_8bit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// write_data[7:0]
	input  logic [ptc_pkg::IN_DATA_W-1:0]    s_tdata,
	// command[1:0]
	input  logic [ptc_pkg::CMD_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// counter_value[7:0], flag_byte[15:8], counter_stepped[16], zeros[23:17]
	output logic [ptc_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ptc_pkg::DATA_W-1:0]       cfg_data
);
	import ptc_pkg::*;

	cfg_t                 cfg;
	timer_state_t         state_q;
	timer_state_t         state_nxt;
	logic                 stepped_nxt;
	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [DATA_W-1:0]    data_s1;
	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_counter_q;
	logic [DATA_W-1:0]    out_flags_q;
	logic                 out_stepped_q;
	logic                 advance;

	assign cfg_ready = 1'b1;

	ptc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ptc_update u_update (
		.cfg        (cfg),
		.cur        (state_q),
		.command    (cmd_s1),
		.write_data (data_s1),
		.nxt        (state_nxt),
		.stepped    (stepped_nxt)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_counter_q <= state_nxt.counter;
			out_flags_q   <= state_nxt.flags;
			out_stepped_q <= stepped_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2*DATA_W - 1){1'b0}}, out_stepped_q,
	                   out_flags_q, out_counter_q};

endmodule

FILE: src/ptc_cfg_regs.sv
module ptc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ptc_pkg::DATA_W-1:0]     wr_data,
	output ptc_pkg::cfg_t                  cfg
);
	import ptc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CLK_SEL:       cfg_q.clk_sel       <= wr_data[SEL_W-1:0];
				REG_WAVEFORM_MODE: cfg_q.waveform_mode <= wr_data[MODE_W-1:0];
				REG_COMPARE_A:     cfg_q.compare_a     <= wr_data;
				REG_COMPARE_B:     cfg_q.compare_b     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/ptc_update.sv
module ptc_update (
	input  ptc_pkg::cfg_t                cfg,
	input  ptc_pkg::timer_state_t        cur,
	input  logic [ptc_pkg::CMD_W-1:0]    command,
	input  logic [ptc_pkg::DATA_W-1:0]   write_data,
	output ptc_pkg::timer_state_t        nxt,
	output logic                         stepped
);
	import ptc_pkg::*;

	logic [PRESCALE_W-1:0] pre_inc;
	logic [DATA_W-1:0]     ctr_inc;
	logic [DATA_W-1:0]     ctr_after_a;
	logic                  match_a;
	logic                  clears_a;

	always_comb begin
		pre_inc     = cur.prescale_count + 1'b1;
		ctr_inc     = cur.counter + 1'b1;
		match_a     = (ctr_inc == cfg.compare_a);
		clears_a    = (cfg.waveform_mode inside {MODE_CTC_A, MODE_PWM_A, MODE_FAST_A});
		ctr_after_a = (match_a && clears_a) ? '0 : ctr_inc;

		nxt     = cur;
		stepped = 1'b0;
		case (command)
			CMD_TICK: begin
				if (cfg.clk_sel != SEL_STOPPED) begin
					nxt.prescale_count = pre_inc;
					if (pre_inc >= divisor_of(cfg.clk_sel)) begin
						nxt.prescale_count = '0;
						nxt.counter        = ctr_after_a;
						stepped            = 1'b1;
						if (cur.counter == COUNTER_TOP)
							nxt.flags[FLAG_OVERFLOW_BIT] = 1'b1;
						if (match_a)
							nxt.flags[FLAG_MATCH_A_BIT] = 1'b1;
						if (ctr_after_a == cfg.compare_b)
							nxt.flags[FLAG_MATCH_B_BIT] = 1'b1;
					end
				end
			end
			CMD_WR_COUNTER: nxt.counter = write_data;
			CMD_WR_FLAGS:   nxt.flags   = write_data;
			default: ;
		endcase
	end

endmodule
